// ===== rtl/stereo_early_reflection_taps_defines.svh =====
// assertion helpers for the early reflection tap block
`ifndef STEREO_EARLY_REFLECTION_TAPS_DEFINES_SVH
`define STEREO_EARLY_REFLECTION_TAPS_DEFINES_SVH

// clocking and reset qualifier shared by every check
`define SERT_CLKED(clk, rst_n) @(posedge clk) disable iff (!rst_n)

// concurrent check with a fixed failure message
`define SERT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (`SERT_CLKED(clk, rst_n) prop) \
    else $error("sert check failed");

`endif

// ===== rtl/sert_pkg.sv =====
`default_nettype none

package sert_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DATA_W     = 2 * SAMPLE_W;
  localparam int unsigned PRE_W      = 13;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam int unsigned TAP_COUNT  = 8;
  localparam int unsigned TAP_SHIFT  = 3;
  localparam int unsigned TAP_TOTAL  = 2 * TAP_COUNT;
  localparam int unsigned SUM_W      = SAMPLE_W + TAP_SHIFT;

  localparam logic [GAIN_W-1:0] UNITY_Q15 = 16'h8000;

  // register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PREDELAY = 2'd0,
    CFG_LEVEL    = 2'd1,
    CFG_WIDTH    = 2'd2
  } cfg_idx_e;

  // tap times in tenths of a millisecond, left taps first then right taps
  localparam int unsigned TAP_TENTHS [TAP_TOTAL] = '{
    29, 51, 74, 117, 132, 179, 236, 318,
    33, 60, 87, 121, 145, 194, 261, 340
  };
  localparam int unsigned LONGEST_TAP_TENTHS = 340;

endpackage

`default_nettype wire

// ===== rtl/stereo_early_reflection_taps.sv =====
// Stereo early reflection taps.
// Input stream s_axis carries one stereo frame per transfer; output stream m_axis
// carries one processed frame for every input frame, in order.
// Each frame writes its mono average into a circular delay memory, then 16 taps
// (8 left, 8 right) are read one per cycle from that single-port-read memory,
// summed, and mixed into the dry samples as mid and side terms.
// The next frame is taken only after the 16 sequential tap reads, the last read
// data, one multiply stage and one output stage of the frame before are done.
// The input is taken only while the sequencer is idle; a finished result sits
// in the output register, so the next frame may be accepted while it waits.
// If the receiver stalls, the next result holds in the output stage until the
// register frees up, and no further input is taken meanwhile.
// Reset returns the write position and gains to their defaults; memory entries
// never written since reset read as zero through a fill flag, so no clearing
// pass is needed. Configuration writes take effect at the next clock edge.
`default_nettype none

module stereo_early_reflection_taps #(
  parameter int unsigned DELAY_DEPTH = 16384,
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] left_sample, [31:16] right_sample
  input  logic [sert_pkg::DATA_W-1:0]         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] left_out, [31:16] right_out
  output logic [sert_pkg::DATA_W-1:0]         m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [sert_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [sert_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  import sert_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned LONGEST_OFF = (LONGEST_TAP_TENTHS * SAMPLE_RATE + 5000) / 10000;
  localparam int unsigned PRE_LIMIT =
    (DELAY_DEPTH - 1 > LONGEST_OFF) ? DELAY_DEPTH - 1 - LONGEST_OFF : 0;
  localparam int unsigned CNT_W = $clog2(TAP_TOTAL) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_OUT
  } state_e;

  // tap offset table, fixed for the sample rate
  logic [AW-1:0] tap_off_tbl [TAP_TOTAL];
  for (genvar g = 0; g < TAP_TOTAL; g++) begin : g_tap
    localparam int unsigned OFF = (TAP_TENTHS[g] * SAMPLE_RATE + 5000) / 10000;
    assign tap_off_tbl[g] = AW'(OFF);
  end

  function automatic logic [SAMPLE_W-1:0] sat16(logic signed [SAMPLE_W+2:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v > (SAMPLE_W+3)'(signed'(32767))) begin
      r = 16'h7fff;
    end else if (v < -(SAMPLE_W+3)'(signed'(32768))) begin
      r = 16'h8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // control state
  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                rd_pend_q;
  logic [AW-1:0]       wp_q;
  logic                wrapped_q;
  logic                m_valid_q;
  logic [PRE_W-1:0]    pre_q;
  logic [GAIN_W-1:0]   level_q;
  logic [GAIN_W-1:0]   width_q;

  // payload
  logic signed [SAMPLE_W-1:0] l_q, r_q;
  logic signed [SUM_W-1:0]    sum_l_q, sum_r_q;
  logic [SAMPLE_W-1:0]        rd_data_q;
  logic                       rd_hit_q;
  logic                       rd_right_q;
  logic [GAIN_W-1:0]          side_gain_q;
  logic signed [SAMPLE_W:0]   mid_q, side_q;
  logic [DATA_W-1:0]          m_data_q;

  logic [SAMPLE_W-1:0] mono_delay_store [DELAY_DEPTH];

  logic                in_fire;
  logic                out_load;
  logic                rd_en;
  logic [AW:0]         off_w;
  logic [AW:0]         diff_w;
  logic [AW-1:0]       rd_idx;
  logic                rd_hit;
  logic signed [SAMPLE_W:0] in_sum;
  logic [CFG_DATA_W-1:0]    gain_clamped;
  logic [PRE_W-1:0]         pre_clamped;
  logic [2*GAIN_W-1:0]      gain_prod;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // configuration values clamped on the way in
  assign gain_clamped = (cfg_wdata_i > UNITY_Q15) ? UNITY_Q15 : cfg_wdata_i;
  assign pre_clamped  = (32'(cfg_wdata_i[PRE_W-1:0]) > PRE_LIMIT) ?
                        PRE_W'(PRE_LIMIT) : cfg_wdata_i[PRE_W-1:0];

  // tap read address: write position minus offset, modulo depth
  assign rd_en  = (state_q == ST_READ) && !cnt_q[CNT_W-1];
  assign off_w  = (AW+1)'(pre_q) + (AW+1)'(tap_off_tbl[cnt_q[CNT_W-2:0]]);
  assign diff_w = {1'b0, wp_q} - off_w;
  assign rd_idx = diff_w[AW] ? (diff_w[AW-1:0] + AW'(DELAY_DEPTH)) : diff_w[AW-1:0];
  // entries behind the write position are filled; past it only after a wrap
  assign rd_hit = !diff_w[AW] || wrapped_q;

  assign in_sum    = (SAMPLE_W+1)'(signed'(s_axis_tdata[SAMPLE_W-1:0])) +
                     (SAMPLE_W+1)'(signed'(s_axis_tdata[DATA_W-1:SAMPLE_W]));
  assign gain_prod = level_q * width_q;

  // sequencer, write position and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      m_valid_q <= 1'b0;
      pre_q     <= '0;
      level_q   <= '0;
      width_q   <= UNITY_Q15;
    end else begin
      rd_pend_q <= rd_en;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_PREDELAY: pre_q   <= pre_clamped;
          CFG_LEVEL:    level_q <= gain_clamped;
          CFG_WIDTH:    width_q <= gain_clamped;
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_q   <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[CNT_W-1]) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
            if (wp_q == AW'(DELAY_DEPTH - 1)) begin
              wp_q      <= '0;
              wrapped_q <= 1'b1;
            end else begin
              wp_q <= wp_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // delay memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mono_delay_store[wp_q] <= in_sum[SAMPLE_W:1];
    end
    if (rd_en) begin
      rd_data_q <= mono_delay_store[rd_idx];
    end
  end

  // tap accumulation and mixing datapath
  always_ff @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] er_l, er_r;
    logic signed [SAMPLE_W:0]   pair_sum, pair_diff;
    logic signed [2*SAMPLE_W:0] mid_prod, side_prod;
    er_l      = sum_l_q[SUM_W-1:TAP_SHIFT];
    er_r      = sum_r_q[SUM_W-1:TAP_SHIFT];
    pair_sum  = (SAMPLE_W+1)'(er_l) + (SAMPLE_W+1)'(er_r);
    pair_diff = (SAMPLE_W+1)'(er_l) - (SAMPLE_W+1)'(er_r);
    mid_prod  = signed'(pair_sum[SAMPLE_W:1]) * signed'({1'b0, level_q});
    side_prod = signed'(pair_diff[SAMPLE_W:1]) * signed'({1'b0, side_gain_q});

    side_gain_q <= gain_prod[2*GAIN_W-2:GAIN_W-1];
    rd_hit_q    <= rd_hit;
    rd_right_q  <= cnt_q[CNT_W-2];

    if (in_fire) begin
      l_q     <= s_axis_tdata[SAMPLE_W-1:0];
      r_q     <= s_axis_tdata[DATA_W-1:SAMPLE_W];
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (rd_pend_q && rd_hit_q) begin
      if (rd_right_q) begin
        sum_r_q <= sum_r_q + SUM_W'(signed'(rd_data_q));
      end else begin
        sum_l_q <= sum_l_q + SUM_W'(signed'(rd_data_q));
      end
    end

    if (state_q == ST_MUL) begin
      mid_q  <= mid_prod[2*SAMPLE_W-1:SAMPLE_W-1];
      side_q <= side_prod[2*SAMPLE_W-1:SAMPLE_W-1];
    end

    if (out_load) begin
      m_data_q <= {sat16((SAMPLE_W+3)'(r_q) + (SAMPLE_W+3)'(mid_q) - (SAMPLE_W+3)'(side_q)),
                   sat16((SAMPLE_W+3)'(l_q) + (SAMPLE_W+3)'(mid_q) + (SAMPLE_W+3)'(side_q))};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sert_checker.sv =====
`default_nettype none
`include "stereo_early_reflection_taps_defines.svh"

module sert_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sert_pkg::DATA_W-1:0]     m_axis_tdata
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result stays offered
  `SERT_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid)
  // a stalled result keeps its data
  `SERT_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(m_axis_tdata))
  // one frame in the sequencer at a time: input closes right after a transfer
  `SERT_ASSERT(a_one_frame, clk_i, rst_ni, in_xfer |=> !s_axis_tready)
  // a new result only appears while a frame is being worked on
  `SERT_ASSERT(a_out_from_work, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

endmodule

bind stereo_early_reflection_taps sert_checker u_sert_checker (.*);

`default_nettype wire

// ===== tb/stereo_early_reflection_taps_tb.sv =====
`timescale 1ns / 1ps

module stereo_early_reflection_taps_tb;
  import sert_pkg::*;

  localparam int unsigned DEPTH       = 16384;
  localparam int unsigned RATE        = 48000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 215;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam longint      CYCLE_LIMIT = 2_000_000;
  localparam longint      UNITY       = 32768;
  localparam int unsigned SAMPLE_MAX  = 16'h7fff;
  localparam int unsigned SAMPLE_MIN  = 16'h8000;

  // index with no register behind it
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  // one stereo frame, left in the low half
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } frame_t;

  typedef enum logic {
    ROW_FRAME,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [CFG_DATA_W-1:0]   value;
    frame_t                  stim;
    logic                    typed;
    frame_t                  want;
  } row_t;

  // directed rows: with level at zero, or with an empty history behind the taps,
  // the output is the dry input
  localparam int unsigned DIRECTED_ROWS = 21;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_FRAME, '0, '0, '{16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
    '{ROW_FRAME, '0, '0, '{16'sd32767, 16'sd32767}, 1'b1, '{16'sd32767, 16'sd32767}},
    '{ROW_FRAME, '0, '0, '{-16'sd32768, -16'sd32768}, 1'b1,
      '{-16'sd32768, -16'sd32768}},
    '{ROW_FRAME, '0, '0, '{-16'sd32768, 16'sd32767}, 1'b1, '{-16'sd32768, 16'sd32767}},
    '{ROW_FRAME, '0, '0, '{16'sd32767, -16'sd32768}, 1'b1, '{16'sd32767, -16'sd32768}},
    '{ROW_FRAME, '0, '0, '{16'h5555, 16'haaaa}, 1'b1, '{16'h5555, 16'haaaa}},
    '{ROW_FRAME, '0, '0, '{16'shffff, 16'sd1}, 1'b1, '{16'shffff, 16'sd1}},
    // level above unity clips to unity
    '{ROW_WRITE, CFG_LEVEL, 16'hffff, '0, 1'b0, '0},
    // write to an index with no register is dropped
    '{ROW_WRITE, CFG_UNUSED, 16'h1234, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{-16'sd12345, 16'sd12345}, 1'b1, '{-16'sd12345, 16'sd12345}},
    // upper bits of the predelay write are dropped
    '{ROW_WRITE, CFG_PREDELAY, 16'hffff, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_WIDTH, 16'h0000, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{-16'sd32768, -16'sd32768}, 1'b1,
      '{-16'sd32768, -16'sd32768}},
    '{ROW_WRITE, CFG_PREDELAY, 16'h0000, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_WIDTH, 16'hffff, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_LEVEL, 16'h8000, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{-16'sd2000, 16'sd1000}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'sd32767, 16'sd32767}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{-16'sd32768, 16'sd32767}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'sd7, -16'sd7}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'sd0, 16'sd0}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // predictor state
  logic signed [SAMPLE_W-1:0] echo_store [DEPTH];
  int unsigned write_pos;
  int unsigned tap_offset [TAP_TOTAL];
  longint shadow_predelay;
  longint shadow_level;
  longint shadow_width;

  frame_t pending_frames [$];
  bit     no_idle;
  int     error_count;
  int     frames_sent;
  int     frames_checked;
  int     clip_count;
  int     setting_count;
  longint cycle_count;

  always #10 clk_i = ~clk_i;

  stereo_early_reflection_taps #(
    .DELAY_DEPTH(DEPTH),
    .SAMPLE_RATE(RATE)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // tap time in tenths of a millisecond to a rounded sample count
  function automatic int unsigned tenths_to_samples(int unsigned tenths);
    return (tenths * RATE + 5000) / 10000;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip16(longint v);
    if (v > 32767) begin
      clip_count++;
      return 16'sd32767;
    end
    if (v < -32768) begin
      clip_count++;
      return -16'sd32768;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // store the mono feed, read the taps and mix into the dry frame
  function automatic frame_t mix_frame(logic signed [SAMPLE_W-1:0] l,
                                       logic signed [SAMPLE_W-1:0] r);
    longint mono;
    longint sum_l;
    longint sum_r;
    longint avg;
    longint hd;
    longint mid;
    longint side_gain;
    longint side;
    longint pre;
    longint pre_cap;
    longint off;
    int unsigned idx;
    frame_t f;
    mono = (longint'(l) + longint'(r)) >>> 1;
    echo_store[write_pos] = mono[SAMPLE_W-1:0];
    pre_cap = longint'(DEPTH) - 1 - longint'(tenths_to_samples(LONGEST_TAP_TENTHS));
    if (pre_cap < 0) pre_cap = 0;
    pre = (shadow_predelay > pre_cap) ? pre_cap : shadow_predelay;
    sum_l = 0;
    sum_r = 0;
    for (int i = 0; i < TAP_TOTAL; i++) begin
      off = pre + longint'(tap_offset[i]);
      if (off >= DEPTH) off = DEPTH - 1;
      idx = (write_pos + DEPTH - int'(off)) % DEPTH;
      if (i < TAP_COUNT) sum_l += echo_store[idx];
      else sum_r += echo_store[idx];
    end
    sum_l = sum_l >>> TAP_SHIFT;
    sum_r = sum_r >>> TAP_SHIFT;
    avg = (sum_l + sum_r) >>> 1;
    hd = (sum_l - sum_r) >>> 1;
    mid = (avg * shadow_level) >>> 15;
    side_gain = (shadow_level * shadow_width) >>> 15;
    side = (hd * side_gain) >>> 15;
    f.left = clip16(longint'(l) + mid + side);
    f.right = clip16(longint'(r) + mid - side);
    write_pos = (write_pos + 1) % DEPTH;
    return f;
  endfunction

  function automatic int gap_len();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SAMPLE_MAX[SAMPLE_W-1:0];
    if (pick == 1) return SAMPLE_MIN[SAMPLE_W-1:0];
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 20) $display("error: %s", msg);
  endtask

  // compare one output transfer with the oldest expected frame
  task automatic check_frame(frame_t got);
    frame_t want;
    if (pending_frames.size() == 0) begin
      report_error($sformatf("output transfer %0d with nothing pending", frames_checked));
      return;
    end
    want = pending_frames.pop_front();
    if (got.left !== want.left)
      report_error($sformatf("frame %0d left_out got %0d expected %0d",
                             frames_checked, got.left, want.left));
    if (got.right !== want.right)
      report_error($sformatf("frame %0d right_out got %0d expected %0d",
                             frames_checked, got.right, want.right));
    frames_checked++;
  endtask

  // stop sending and wait for every pending frame to come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (addr)
      CFG_PREDELAY: shadow_predelay = longint'(value[PRE_W-1:0]);
      CFG_LEVEL: shadow_level = (longint'(value) > UNITY) ? UNITY : longint'(value);
      CFG_WIDTH: shadow_width = (longint'(value) > UNITY) ? UNITY : longint'(value);
      default: ;
    endcase
  endtask

  // one input transfer, expectation queued at the accepting edge
  task automatic drive_frame(frame_t stim, logic typed, frame_t want);
    int gap;
    frame_t got;
    gap = gap_len();
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= stim;
    do @(posedge clk_i); while (!s_axis_tready);
    got = mix_frame(stim.left, stim.right);
    pending_frames.insert(pending_frames.size(), typed ? want : got);
    frames_sent++;
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_frame(frame_t'(m_axis_tdata));
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = gap_len();
        m_axis_tready <= (stall == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    frame_t stim;
    logic [CFG_DATA_W-1:0] pre_val;
    logic [CFG_DATA_W-1:0] level_val;
    logic [CFG_DATA_W-1:0] width_val;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    no_idle = 1'b0;
    error_count = 0;
    frames_sent = 0;
    frames_checked = 0;
    clip_count = 0;
    setting_count = 0;
    cycle_count = 0;
    write_pos = 0;
    shadow_predelay = 0;
    shadow_level = 0;
    shadow_width = UNITY;
    for (int i = 0; i < DEPTH; i++) echo_store[i] = '0;
    for (int i = 0; i < TAP_TOTAL; i++) tap_offset[i] = tenths_to_samples(TAP_TENTHS[i]);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) write_reg(DIRECTED[i].addr, DIRECTED[i].value);
      else drive_frame(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          pre_val = 16'h0000;
          level_val = 16'h8000;
          width_val = 16'h8000;
        end
        1: begin
          pre_val = 16'h1fff;
          level_val = 16'hffff;
          width_val = 16'h0000;
        end
        2: begin
          pre_val = 16'he000;
          level_val = 16'h0000;
          width_val = 16'hffff;
        end
        3: begin
          pre_val = 16'd100;
          level_val = 16'h8000;
          width_val = 16'h8000;
        end
        default: begin
          pre_val = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65535))
                                                : CFG_DATA_W'($urandom_range(0, 300));
          level_val = CFG_DATA_W'($urandom_range(0, 65535));
          width_val = CFG_DATA_W'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CFG_PREDELAY, pre_val);
      write_reg(CFG_LEVEL, level_val);
      write_reg(CFG_WIDTH, width_val);
      if (p % 2 == 1) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
      setting_count++;
      no_idle = (p % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        stim.left = pick_sample();
        stim.right = pick_sample();
        drive_frame(stim, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // wait out the pipeline, then look for stray transfers
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_frames.size() != 0)
      report_error($sformatf("%0d frames never came out", pending_frames.size()));

    $display("sent %0d frames, checked %0d, over %0d random settings phases",
             frames_sent, frames_checked, setting_count);
    $display("%0d output samples clipped, %0d errors", clip_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== stereo_early_reflection_taps.f =====
+incdir+rtl
rtl/sert_pkg.sv
rtl/stereo_early_reflection_taps.sv
rtl/sert_checker.sv
tb/stereo_early_reflection_taps_tb.sv
